@@ src/bmp_pkg.sv @@
// ----------------------------------------------------------------------------
// Bitmap stream parser package
// Shared types and constants for the 24-bit bitmap stream parser.
// ----------------------------------------------------------------------------
package bmp_pkg;

  localparam int unsigned HdrLen   = 54;
  localparam int unsigned WidthPos = 18;
  localparam int unsigned HeightPos = 22;
  localparam int unsigned DepthPos = 28;
  localparam int unsigned DepthRgb = 24;

  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_PIXEL  = 4'b0010,
    PH_PAD    = 4'b0100,
    PH_IDLE   = 4'b1000
  } phase_e;

  typedef enum logic [1:0] {
    KIND_PIXEL     = 2'd0,
    KIND_HEADER    = 2'd1,
    KIND_BAD_DEPTH = 2'd2,
    KIND_TOO_LARGE = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [11:0] pixel_row;
    logic [11:0] pixel_col;
    logic        last_pixel;
    logic [12:0] image_width;
    logic [12:0] image_height;
  } result_t;

endpackage

@@ src/bmp_in_if.sv @@
// ----------------------------------------------------------------------------
// Bitmap byte input channel
// Valid/ready channel that carries one file byte and its start mark per beat.
// ----------------------------------------------------------------------------
interface bmp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       file_start;

  modport source (output valid, output data_byte, output file_start, input ready);
  modport sink   (input valid, input data_byte, input file_start, output ready);
endinterface

@@ src/bmp_out_if.sv @@
// ----------------------------------------------------------------------------
// Bitmap result output channel
// Valid/ready channel that carries one pixel or header result per beat.
// ----------------------------------------------------------------------------
interface bmp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [11:0] pixel_row;
  logic [11:0] pixel_col;
  logic        last_pixel;
  logic [12:0] image_width;
  logic [12:0] image_height;

  modport source (output valid, output kind, output red, output green, output blue,
                  output pixel_row, output pixel_col, output last_pixel,
                  output image_width, output image_height, input ready);
  modport sink   (input valid, input kind, input red, input green, input blue,
                  input pixel_row, input pixel_col, input last_pixel,
                  input image_width, input image_height, output ready);
endinterface

@@ src/bmp_parse_core.sv @@
// ----------------------------------------------------------------------------
// Bitmap parse core
// Header field capture, pixel assembly and row padding skip, one byte a beat.
// ----------------------------------------------------------------------------
module bmp_parse_core #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       data_byte_i,
  input  logic             file_start_i,
  output logic             res_valid_o,
  output bmp_pkg::result_t res_o
);
  import bmp_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_DIM + 1);

  phase_e            phase_q, phase_d, phase_c;
  logic [5:0]        pos_q, pos_d, pos_c;
  logic [31:0]       width_q, width_d, width_c;
  logic [31:0]       height_q, height_d, height_c;
  logic [15:0]       depth_q, depth_d, depth_c;
  logic [CntW-1:0]   col_q, col_d, col_c;
  logic [CntW-1:0]   row_q, row_d, row_c;
  logic [1:0]        bph_q, bph_d, bph_c;
  logic [1:0]        pad_q, pad_d, pad_c;
  logic [7:0]        blue_q, blue_d;
  logic [7:0]        green_q, green_d;
  logic              last;
  result_t           res;
  logic              res_valid;

  always_comb begin
    phase_c  = phase_q;
    pos_c    = pos_q;
    width_c  = width_q;
    height_c = height_q;
    depth_c  = depth_q;
    col_c    = col_q;
    row_c    = row_q;
    bph_c    = bph_q;
    pad_c    = pad_q;
    if (file_start_i) begin
      phase_c  = PH_HEADER;
      pos_c    = '0;
      width_c  = '0;
      height_c = '0;
      depth_c  = '0;
      col_c    = '0;
      row_c    = '0;
      bph_c    = '0;
      pad_c    = '0;
    end

    phase_d   = phase_c;
    pos_d     = pos_c;
    width_d   = width_c;
    height_d  = height_c;
    depth_d   = depth_c;
    col_d     = col_c;
    row_d     = row_c;
    bph_d     = bph_c;
    pad_d     = pad_c;
    blue_d    = blue_q;
    green_d   = green_q;
    last      = 1'b0;
    res       = '0;
    res_valid = 1'b0;

    unique case (phase_c)
      PH_HEADER: begin
        for (int k = 0; k < 4; k++) begin
          if (pos_c == 6'(WidthPos + k)) width_d[8*k +: 8] = data_byte_i;
          if (pos_c == 6'(HeightPos + k)) height_d[8*k +: 8] = data_byte_i;
        end
        for (int k = 0; k < 2; k++) begin
          if (pos_c == 6'(DepthPos + k)) depth_d[8*k +: 8] = data_byte_i;
        end
        pos_d = pos_c + 6'd1;
        if (pos_c == 6'(HdrLen - 1)) begin
          res_valid          = 1'b1;
          res.image_width    = width_d[12:0];
          res.image_height   = height_d[12:0];
          if (depth_d != 16'(DepthRgb)) begin
            res.kind = KIND_BAD_DEPTH;
            phase_d  = PH_IDLE;
          end else if (width_d > 32'(MAX_DIM) || height_d > 32'(MAX_DIM)) begin
            res.kind = KIND_TOO_LARGE;
            phase_d  = PH_IDLE;
          end else begin
            res.kind = KIND_HEADER;
            phase_d  = (width_d == '0 || height_d == '0) ? PH_IDLE : PH_PIXEL;
          end
        end
      end
      PH_PIXEL: begin
        case (bph_c)
          2'd0: begin
            blue_d = data_byte_i;
            bph_d  = 2'd1;
          end
          2'd1: begin
            green_d = data_byte_i;
            bph_d   = 2'd2;
          end
          default: begin
            bph_d = 2'd0;
            last  = (32'(row_c) + 32'd1 == height_c) && (32'(col_c) + 32'd1 == width_c);
            res_valid      = 1'b1;
            res.kind       = KIND_PIXEL;
            res.red        = data_byte_i;
            res.green      = green_q;
            res.blue       = blue_q;
            res.pixel_row  = 12'(row_c);
            res.pixel_col  = 12'(col_c);
            res.last_pixel = last;
            col_d = col_c + CntW'(1);
            if (last) begin
              phase_d = PH_IDLE;
            end else if (32'(col_c) + 32'd1 == width_c) begin
              pad_d = width_c[1:0];
              if (width_c[1:0] != 2'd0) begin
                phase_d = PH_PAD;
              end else begin
                col_d = '0;
                row_d = row_c + CntW'(1);
              end
            end
          end
        endcase
      end
      PH_PAD: begin
        pad_d = pad_c - 2'd1;
        if (pad_d == 2'd0) begin
          col_d   = '0;
          row_d   = row_c + CntW'(1);
          phase_d = PH_PIXEL;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HEADER;
      pos_q    <= '0;
      width_q  <= '0;
      height_q <= '0;
      depth_q  <= '0;
      col_q    <= '0;
      row_q    <= '0;
      bph_q    <= '0;
      pad_q    <= '0;
      blue_q   <= '0;
      green_q  <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      width_q  <= width_d;
      height_q <= height_d;
      depth_q  <= depth_d;
      col_q    <= col_d;
      row_q    <= row_d;
      bph_q    <= bph_d;
      pad_q    <= pad_d;
      blue_q   <= blue_d;
      green_q  <= green_d;
    end
  end

  assign res_valid_o = res_valid;
  assign res_o       = res;

endmodule

@@ src/bmp_24bit_stream_parser.sv @@
// ----------------------------------------------------------------------------
// 24-bit bitmap stream parser
// Parses a bitmap file byte by byte and emits header and pixel results.
//
//   Channel   Dir   Beat contents
//   in_i      in    data_byte, file_start
//   out_o     out   kind, red, green, blue, pixel_row, pixel_col, last_pixel,
//                   image_width, image_height
//
// One input beat is taken every cycle while not stalled; its result, if any,
// appears from the output register in the next cycle. The input is stalled
// only while that register holds a result that the sink has not taken. Reset
// puts the parser in the header phase with all counters and fields cleared.
// ----------------------------------------------------------------------------
module bmp_24bit_stream_parser #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bmp_in_if.sink    in_i,
  bmp_out_if.source out_o
);
  import bmp_pkg::*;

  logic    step;
  logic    res_valid;
  result_t res;
  logic    out_valid_q, out_valid_d;
  result_t out_q;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign step       = in_i.valid && in_i.ready;

  bmp_parse_core #(
    .MAX_DIM (MAX_DIM)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .data_byte_i  (in_i.data_byte),
    .file_start_i (in_i.file_start),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (step && res_valid) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_valid) begin
      out_q <= res;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.kind         = out_q.kind;
  assign out_o.red          = out_q.red;
  assign out_o.green        = out_q.green;
  assign out_o.blue         = out_q.blue;
  assign out_o.pixel_row    = out_q.pixel_row;
  assign out_o.pixel_col    = out_q.pixel_col;
  assign out_o.last_pixel   = out_q.last_pixel;
  assign out_o.image_width  = out_q.image_width;
  assign out_o.image_height = out_q.image_height;

endmodule
